FILE: sv/rfptc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// RF pulse train capture package
// Shared types, codes and sizing constants for the pulse train capture block.
// ----------------------------------------------------------------------------
package rfptc_pkg;

  localparam int MAX_PULSES = 255;
  localparam int STORE_DEPTH = MAX_PULSES + 1;
  localparam int CNT_W = $clog2(MAX_PULSES + 1);

  localparam int DIV_STEPS = 32;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PULSE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PREAMBLE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_END_TIMEOUT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_COUNT = 3'd4;

  localparam logic [1:0] OP_EDGE = 2'd0;
  localparam logic [1:0] OP_TICK = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;
  localparam logic [1:0] OP_READ = 2'd3;

  localparam logic [2:0] ST_IGNORED = 3'd0;
  localparam logic [2:0] ST_STARTED = 3'd1;
  localparam logic [2:0] ST_STORED = 3'd2;
  localparam logic [2:0] ST_DROPPED = 3'd3;
  localparam logic [2:0] ST_READY = 3'd4;
  localparam logic [2:0] ST_READ = 3'd5;
  localparam logic [2:0] ST_NONE = 3'd6;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] time_us;
    logic        pin_level;
    logic [7:0]  read_index;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  pulse_count;
    logic        frame_ready;
    logic [15:0] read_value;
  } out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_DIV,
    S_WR,
    S_OUT
  } state_t;

endpackage
`default_nettype wire

FILE: sv/rf_pulse_train_capture.sv
// An item that stores a pulse passes evaluation, the bit-serial divider that scales
// the width (32 steps), the store write and the output register; other items skip
// the divider and the write. A new item is taken only after the last is output.
// Reset: synchronous, active low; clears the frame state and loads register defaults.
// The pulse store is not cleared; entries hold nothing defined until written.
`default_nettype none
// ----------------------------------------------------------------------------
// RF pulse train capture
// Turns timestamped receiver edges into a frame of pulse widths scaled by the
// sample rate, with noise rejection, end-of-frame timeout and pulse read-back.
// ----------------------------------------------------------------------------
module rf_pulse_train_capture
  import rfptc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_t                   in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_t                       out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [15:0] mem [STORE_DEPTH];

  state_t state_r, state_nxt;
  in_t    item_r, item_nxt;
  out_t   out_r, out_nxt;
  logic   out_valid_r, out_valid_nxt;

  logic [7:0]  rate_r;
  logic [15:0] min_pulse_r;
  logic [15:0] min_pre_r;
  logic [19:0] timeout_r;
  logic [7:0]  min_count_r;

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             started_r, started_nxt;
  logic             ready_r, ready_nxt;
  logic             enabled_r, enabled_nxt;
  logic [31:0]      last_r, last_nxt;
  logic [31:0]      dl_r, dl_nxt;
  logic             armed_r, armed_nxt;

  logic [2:0]           status_r, status_nxt;
  logic                 rd_ok_r, rd_ok_nxt;
  logic [15:0]          rd_data_r;
  logic                 rd_en;
  logic [CNT_W-1:0]     rd_addr;
  logic [CNT_W-1:0]     wr_addr_r, wr_addr_nxt;
  logic                 mem_we;
  logic [31:0]          num_r, num_nxt;
  logic [7:0]           rem_r, rem_nxt;
  logic [7:0]           div_r, div_nxt;
  logic [DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;
  logic [15:0]          q_sat;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign rd_addr   = CNT_W'(item_r.read_index);
  assign q_sat     = (|num_r[31:16]) ? 16'hFFFF : num_r[15:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r      <= 8'd1;
      min_pulse_r <= 16'd50;
      min_pre_r   <= 16'd400;
      timeout_r   <= 20'd5000;
      min_count_r <= 8'd24;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SAMPLE_RATE:  rate_r      <= cfg_wdata[7:0];
        CFG_MIN_PULSE:    min_pulse_r <= cfg_wdata[15:0];
        CFG_MIN_PREAMBLE: min_pre_r   <= cfg_wdata[15:0];
        CFG_END_TIMEOUT:  timeout_r   <= cfg_wdata;
        CFG_MIN_COUNT:    min_count_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr_r] <= q_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      started_r   <= 1'b0;
      ready_r     <= 1'b0;
      enabled_r   <= 1'b0;
      last_r      <= '0;
      dl_r        <= '0;
      armed_r     <= 1'b0;
      div_cnt_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      started_r   <= started_nxt;
      ready_r     <= ready_nxt;
      enabled_r   <= enabled_nxt;
      last_r      <= last_nxt;
      dl_r        <= dl_nxt;
      armed_r     <= armed_nxt;
      div_cnt_r   <= div_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r    <= item_nxt;
    out_r     <= out_nxt;
    status_r  <= status_nxt;
    rd_ok_r   <= rd_ok_nxt;
    wr_addr_r <= wr_addr_nxt;
    num_r     <= num_nxt;
    rem_r     <= rem_nxt;
    div_r     <= div_nxt;
  end

  always_comb begin
    logic [31:0]    width;
    logic           noise;
    logic           started_eff;
    logic [CNT_W:0] cnt_inc;
    logic           do_end;
    logic           do_store;
    logic [31:0]    store_src;
    logic [31:0]    eto32;
    logic [8:0]     rem_sh;
    logic [8:0]     rem_sub;

    state_nxt     = state_r;
    item_nxt      = item_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    cnt_nxt       = cnt_r;
    started_nxt   = started_r;
    ready_nxt     = ready_r;
    enabled_nxt   = enabled_r;
    last_nxt      = last_r;
    dl_nxt        = dl_r;
    armed_nxt     = armed_r;
    status_nxt    = status_r;
    rd_ok_nxt     = rd_ok_r;
    wr_addr_nxt   = wr_addr_r;
    num_nxt       = num_r;
    rem_nxt       = rem_r;
    div_nxt       = div_r;
    div_cnt_nxt   = div_cnt_r;
    rd_en         = 1'b0;
    mem_we        = 1'b0;

    eto32       = 32'(timeout_r);
    width       = item_r.time_us - last_r;
    noise       = width < 32'(min_pulse_r);
    started_eff = started_r && !noise;
    cnt_inc     = {1'b0, cnt_r} + (CNT_W + 1)'(1);
    do_end      = 1'b0;
    do_store    = 1'b0;
    store_src   = width;
    rem_sh      = {rem_r, num_r[31]};
    rem_sub     = rem_sh - {1'b0, div_r};

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_data;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        rd_ok_nxt = 1'b0;
        unique case (item_r.opcode)
          OP_EDGE: begin
            if (!enabled_r || ready_r) begin
              status_nxt = ST_IGNORED;
            end else begin
              last_nxt = item_r.time_us;
              if (noise) begin
                armed_nxt   = 1'b0;
                dl_nxt      = '0;
                cnt_nxt     = '0;
                started_nxt = 1'b0;
              end
              if (!started_eff) begin
                if (!item_r.pin_level) begin
                  status_nxt = started_r ? ST_DROPPED : ST_IGNORED;
                end else begin
                  started_nxt = 1'b1;
                  dl_nxt      = item_r.time_us + eto32;
                  armed_nxt   = 1'b1;
                  status_nxt  = ST_STARTED;
                end
              end else if (width > eto32) begin
                do_end = 1'b1;
              end else if (32'(cnt_inc) >= MAX_PULSES ||
                           (cnt_r == '0 && width < 32'(min_pre_r))) begin
                armed_nxt   = 1'b0;
                dl_nxt      = '0;
                cnt_nxt     = '0;
                started_nxt = 1'b0;
                status_nxt  = ST_DROPPED;
              end else begin
                cnt_nxt    = cnt_inc[CNT_W-1:0];
                do_store   = 1'b1;
                dl_nxt     = item_r.time_us + eto32;
                armed_nxt  = 1'b1;
                status_nxt = ST_STORED;
              end
            end
          end
          OP_TICK: begin
            if (ready_r || !armed_r) begin
              status_nxt = ST_NONE;
            end else if (item_r.time_us == dl_r || (item_r.time_us - dl_r) >= 32'h8000_0000) begin
              status_nxt = ST_NONE;
            end else begin
              do_end = 1'b1;
            end
          end
          OP_RESTART: begin
            enabled_nxt = 1'b1;
            ready_nxt   = 1'b0;
            armed_nxt   = 1'b0;
            dl_nxt      = '0;
            cnt_nxt     = '0;
            started_nxt = 1'b0;
            status_nxt  = ST_NONE;
          end
          OP_READ: begin
            rd_en      = 1'b1;
            rd_ok_nxt  = (32'(item_r.read_index) <= MAX_PULSES);
            status_nxt = ST_READ;
          end
          default: ;
        endcase

        if (do_end) begin
          if (cnt_r == '0 || 32'(cnt_r) < 32'(min_count_r)) begin
            armed_nxt   = 1'b0;
            dl_nxt      = '0;
            cnt_nxt     = '0;
            started_nxt = 1'b0;
            status_nxt  = ST_DROPPED;
          end else begin
            enabled_nxt = 1'b0;
            armed_nxt   = 1'b0;
            dl_nxt      = '0;
            cnt_nxt     = cnt_inc[CNT_W-1:0];
            ready_nxt   = 1'b1;
            status_nxt  = ST_READY;
            store_src   = eto32;
            do_store    = (32'(cnt_inc) <= MAX_PULSES);
          end
        end

        if (do_store) begin
          wr_addr_nxt = cnt_inc[CNT_W-1:0];
          num_nxt     = store_src;
          rem_nxt     = '0;
          div_nxt     = (rate_r == '0) ? 8'd1 : rate_r;
          div_cnt_nxt = '0;
          state_nxt   = S_DIV;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_DIV: begin
        if (rem_sh >= {1'b0, div_r}) begin
          rem_nxt = rem_sub[7:0];
          num_nxt = {num_r[30:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[7:0];
          num_nxt = {num_r[30:0], 1'b0};
        end
        div_cnt_nxt = div_cnt_r + DIV_CNT_W'(1);
        if (div_cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = S_WR;
        end
      end
      S_WR: begin
        mem_we    = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_nxt.status      = status_r;
          out_nxt.pulse_count = 8'(cnt_r);
          out_nxt.frame_ready = ready_r;
          out_nxt.read_value  = (status_r == ST_READ && rd_ok_r) ? rd_data_r : 16'd0;
          out_valid_nxt       = 1'b1;
          state_nxt           = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

FILE: sv/rfptc_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// RF pulse train capture checker
// Port-level assertions on the capture block, attached by a bind statement.
// ----------------------------------------------------------------------------
module rfptc_checker
  import rfptc_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("Result changed or vanished before its transfer.");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("Input taken again while an item is in work.");

  a_ready_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_READY |-> out_data.frame_ready)
    else $error("Frame ready status without the frame ready flag.");

  a_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_READ |-> out_data.read_value == 16'd0)
    else $error("Read value is not zero on a non-read result.");

  a_started: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_STARTED |->
      out_data.pulse_count == 8'd0 && !out_data.frame_ready)
    else $error("Frame start with pulses held or a frame ready.");

endmodule

bind rf_pulse_train_capture rfptc_checker u_rfptc_checker (.*);
`default_nettype wire

FILE: dv/tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// RF pulse train capture testbench
// Sends edge, tick, restart and read transfers into the capture block under
// several register settings and handshake idling patterns. A scoreboard
// predicts every result from its own copy of the frame state and compares
// each returned field in order.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rfptc_pkg::*;

  class pulse_capture_sb;
    bit [7:0]  rate_div;
    bit [15:0] min_pulse_width;
    bit [15:0] min_preamble_width;
    bit [19:0] end_timeout;
    bit [7:0]  min_pulse_count;
    bit [15:0] store [STORE_DEPTH];
    bit        written [STORE_DEPTH];
    int unsigned stored_count;
    bit        frame_started;
    bit        ready_flag;
    bit        capture_enabled;
    bit        deadline_armed;
    bit [31:0] last_edge_time;
    bit [31:0] deadline_time;
    out_t      pending_reports [$];
    int unsigned fail_count;

    function new();
      rate_div = 8'd1;
      min_pulse_width = 16'd50;
      min_preamble_width = 16'd400;
      end_timeout = 20'd5000;
      min_pulse_count = 8'd24;
      foreach (written[i]) begin
        written[i] = 1'b0;
        store[i] = '0;
      end
      stored_count = 0;
      frame_started = 1'b0;
      ready_flag = 1'b0;
      capture_enabled = 1'b0;
      deadline_armed = 1'b0;
      last_edge_time = '0;
      deadline_time = '0;
      fail_count = 0;
    endfunction

    function void write_reg(bit [CFG_IDX_W-1:0] idx, bit [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_SAMPLE_RATE: rate_div = val[7:0];
        CFG_MIN_PULSE: min_pulse_width = val[15:0];
        CFG_MIN_PREAMBLE: min_preamble_width = val[15:0];
        CFG_END_TIMEOUT: end_timeout = val[19:0];
        CFG_MIN_COUNT: min_pulse_count = val[7:0];
        default: ;
      endcase
    endfunction

    function bit [15:0] scaled(bit [31:0] us);
      bit [31:0] q;
      q = us / ((rate_div == 8'd0) ? 32'd1 : {24'd0, rate_div});
      return (q > 32'h0000_FFFF) ? 16'hFFFF : q[15:0];
    endfunction

    function void drop_frame();
      deadline_armed = 1'b0;
      deadline_time = '0;
      stored_count = 0;
      frame_started = 1'b0;
    endfunction

    function bit [2:0] close_frame();
      if (stored_count == 0 || stored_count < min_pulse_count) begin
        drop_frame();
        return ST_DROPPED;
      end
      capture_enabled = 1'b0;
      deadline_armed = 1'b0;
      deadline_time = '0;
      stored_count++;
      if (stored_count <= MAX_PULSES) begin
        store[stored_count] = scaled({12'd0, end_timeout});
        written[stored_count] = 1'b1;
      end
      ready_flag = 1'b1;
      return ST_READY;
    endfunction

    function bit [2:0] take_edge(bit [31:0] now, bit level);
      bit [31:0] width;
      bit        was_started;
      if (!capture_enabled || ready_flag) return ST_IGNORED;
      width = now - last_edge_time;
      last_edge_time = now;
      was_started = frame_started;
      if (width < {16'd0, min_pulse_width}) drop_frame();
      if (!frame_started) begin
        if (!level) return was_started ? ST_DROPPED : ST_IGNORED;
        frame_started = 1'b1;
        deadline_time = now + {12'd0, end_timeout};
        deadline_armed = 1'b1;
        return ST_STARTED;
      end
      if (width > {12'd0, end_timeout}) return close_frame();
      if (stored_count + 1 >= MAX_PULSES) begin
        drop_frame();
        return ST_DROPPED;
      end
      stored_count++;
      if (stored_count == 1 && width < {16'd0, min_preamble_width}) begin
        drop_frame();
        return ST_DROPPED;
      end
      store[stored_count] = scaled(width);
      written[stored_count] = 1'b1;
      deadline_time = now + {12'd0, end_timeout};
      deadline_armed = 1'b1;
      return ST_STORED;
    endfunction

    function bit [2:0] take_tick(bit [31:0] now);
      bit [31:0] diff;
      if (ready_flag || !deadline_armed) return ST_NONE;
      diff = now - deadline_time;
      if (diff == 32'd0 || diff[31]) return ST_NONE;
      return close_frame();
    endfunction

    function void track_item(in_t it);
      out_t r;
      r = '0;
      case (it.opcode)
        OP_EDGE: r.status = take_edge(it.time_us, it.pin_level);
        OP_TICK: r.status = take_tick(it.time_us);
        OP_RESTART: begin
          capture_enabled = 1'b1;
          ready_flag = 1'b0;
          drop_frame();
          r.status = ST_NONE;
        end
        default: begin
          if (it.read_index <= MAX_PULSES) r.read_value = store[it.read_index];
          r.status = ST_READ;
        end
      endcase
      r.pulse_count = 8'(stored_count);
      r.frame_ready = ready_flag;
      pending_reports.push_back(r);
    endfunction

    function void check_report(out_t got);
      out_t want;
      if (pending_reports.size() == 0) begin
        $error("result with no pending expectation: status %0d", got.status);
        fail_count++;
        return;
      end
      want = pending_reports.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        fail_count++;
      end
      if (got.pulse_count !== want.pulse_count) begin
        $error("pulse_count: expected %0d, actual %0d", want.pulse_count, got.pulse_count);
        fail_count++;
      end
      if (got.frame_ready !== want.frame_ready) begin
        $error("frame_ready: expected %0d, actual %0d", want.frame_ready, got.frame_ready);
        fail_count++;
      end
      if (got.read_value !== want.read_value) begin
        $error("read_value: expected %0d, actual %0d", want.read_value, got.read_value);
        fail_count++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_t                   in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_t                  out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  pulse_capture_sb sb;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_left = 0;
  bit          want_hold = 1'b0;
  int unsigned sent_items = 0;
  bit [31:0]   clock_us = '0;

  rf_pulse_train_capture u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("rf_pulse_train_capture regression: fail");
    $finish;
  end

  // The long hold-off lets the block fill up and back-pressure its input.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (want_hold) begin
        want_hold = 1'b0;
        hold_left = 400;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_report(out_data);
  end

  task automatic send_item(in_t it);
    int unsigned gap;
    in_data <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.track_item(it);
    sent_items++;
    @(negedge clk);
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_edge(bit [31:0] t, bit lvl);
    in_t it;
    it.opcode = OP_EDGE;
    it.time_us = t;
    it.pin_level = lvl;
    it.read_index = 8'($urandom);
    send_item(it);
  endtask

  task automatic send_tick(bit [31:0] t);
    in_t it;
    it.opcode = OP_TICK;
    it.time_us = t;
    it.pin_level = 1'($urandom);
    it.read_index = 8'($urandom);
    send_item(it);
  endtask

  task automatic send_restart();
    in_t it;
    it.opcode = OP_RESTART;
    it.time_us = $urandom;
    it.pin_level = 1'($urandom);
    it.read_index = 8'($urandom);
    send_item(it);
  endtask

  task automatic send_read(bit [7:0] idx);
    in_t it;
    it.opcode = OP_READ;
    it.time_us = $urandom;
    it.pin_level = 1'($urandom);
    it.read_index = idx;
    send_item(it);
  endtask

  // Only entries that a frame has filled are ever read back.
  function automatic int pick_written();
    int hits [$];
    foreach (sb.written[i]) begin
      if (sb.written[i]) hits.push_back(i);
    end
    if (hits.size() == 0) return -1;
    return hits[$urandom_range(hits.size() - 1)];
  endfunction

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending_reports.size() != 0) @(negedge clk);
  endtask

  task automatic program_regs(bit [7:0] rate, bit [15:0] min_w, bit [15:0] min_pre,
                              bit [19:0] timeout, bit [7:0] min_cnt);
    bit [CFG_DATA_W-1:0] vals [5];
    bit [CFG_IDX_W-1:0]  idx [5];
    vals = '{20'(rate), 20'(min_w), 20'(min_pre), timeout, 20'(min_cnt)};
    idx = '{CFG_SAMPLE_RATE, CFG_MIN_PULSE, CFG_MIN_PREAMBLE, CFG_END_TIMEOUT,
            CFG_MIN_COUNT};
    wait_drained();
    for (int i = 0; i < 5; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= vals[i];
      @(negedge clk);
      sb.write_reg(idx[i], vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic play_frame(int unsigned pulses, bit clean);
    bit [31:0]   w;
    bit [31:0]   lo;
    bit [31:0]   hi;
    bit [31:0]   due;
    bit          lvl;
    int unsigned pick;
    int unsigned reads;
    int          idx;
    send_restart();
    clock_us += $urandom_range(3000, 1);
    send_edge(clock_us, 1'b1);
    lvl = 1'b1;
    for (int unsigned k = 1; k <= pulses; k++) begin
      lo = {16'd0, sb.min_pulse_width};
      if (k == 1 && sb.min_preamble_width > sb.min_pulse_width) begin
        lo = {16'd0, sb.min_preamble_width};
      end
      hi = {12'd0, sb.end_timeout};
      pick = $urandom_range(99);
      if (lo > hi) w = lo;
      else if (pick < 10) w = lo;
      else if (pick < 20) w = hi;
      else if (pick < 23 && !clean && lo != 0) w = $urandom_range(lo - 1);
      else w = $urandom_range(hi, lo);
      if ($urandom_range(99) < 4) send_tick(clock_us + $urandom_range(sb.end_timeout));
      clock_us += w;
      lvl = !lvl;
      send_edge(clock_us, lvl);
    end
    if (sb.deadline_armed) begin
      due = sb.deadline_time;
      pick = $urandom_range(99);
      if (pick < 15) begin
        send_tick(due);
        send_tick(due + 1);
      end else if (pick < 75) begin
        send_tick(due + $urandom_range(100000, 1));
      end else if (pick < 90) begin
        clock_us = sb.last_edge_time + {12'd0, sb.end_timeout} + 1 + $urandom_range(1000);
        send_edge(clock_us, !lvl);
      end else begin
        send_tick(due + 32'h8000_0000 + $urandom_range(1000));
        send_tick(due + 1);
      end
    end
    reads = $urandom_range(5);
    repeat (reads) begin
      idx = pick_written();
      if (idx >= 0) send_read(8'(idx));
    end
  endtask

  task automatic noise_burst(int unsigned count);
    in_t it;
    int  idx;
    repeat (count) begin
      it.opcode = 2'($urandom);
      it.time_us = $urandom;
      it.pin_level = 1'($urandom);
      it.read_index = 8'($urandom);
      if (it.opcode == OP_READ) begin
        idx = pick_written();
        if (idx < 0) it.opcode = OP_TICK;
        else it.read_index = 8'(idx);
      end
      send_item(it);
    end
  endtask

  task automatic run_random(int unsigned quota);
    int unsigned goal;
    int unsigned n;
    int unsigned mc;
    goal = sent_items + quota;
    while (sent_items < goal) begin
      if ($urandom_range(99) < 75) begin
        mc = sb.min_pulse_count;
        if ($urandom_range(99) < 2) n = $urandom_range(255, 250);
        else if (mc <= 40 && $urandom_range(1) == 1) n = $urandom_range(mc + 6, mc);
        else n = $urandom_range(40);
        play_frame(n, 1'b0);
      end else begin
        noise_burst($urandom_range(8, 1));
      end
    end
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // Capture is off until the first restart.
    send_edge(32'd100, 1'b1);
    send_tick(32'd200);
    send_restart();

    // A zero sample rate divides as one.
    program_regs(8'd0, 16'd50, 16'd400, 20'd5000, 8'd2);
    send_edge(32'd1000, 1'b0);
    send_edge(32'd1010, 1'b1);
    send_edge(32'd1300, 1'b0);
    send_edge(32'd1400, 1'b1);
    send_edge(32'd1800, 1'b0);
    send_edge(32'd1850, 1'b1);
    send_edge(32'd1860, 1'b0);
    send_edge(32'd2000, 1'b1);
    send_edge(32'd2500, 1'b0);
    send_edge(32'd7500, 1'b1);
    send_tick(32'd12500);
    send_tick(32'd12501);
    send_edge(32'd13000, 1'b1);
    send_tick(32'd20000);
    send_read(8'd1);
    send_read(8'd3);
    send_restart();
    send_edge(32'd20000, 1'b1);
    send_edge(32'd20500, 1'b0);
    send_edge(32'd30000, 1'b1);
    send_edge(32'd31000, 1'b1);
    send_tick(32'd36001);
    clock_us = 32'd31000;

    program_regs(8'd1, 16'd50, 16'd400, 20'd5000, 8'd24);
    play_frame(254, 1'b1);
    run_random(150);

    program_regs(8'd255, 16'd0, 16'd0, 20'd1000000, 8'd0);
    send_idle_pct = 68;
    play_frame(255, 1'b1);
    run_random(150);

    program_regs(8'd1, 16'd65535, 16'd65535, 20'd1000000, 8'd255);
    send_idle_pct = 0;
    recv_stall_pct = 68;
    run_random(300);

    program_regs(8'd7, 16'd1, 16'd1, 20'd1, 8'd1);
    send_idle_pct = 33;
    recv_stall_pct = 33;
    run_random(300);

    program_regs(8'($urandom_range(255, 1)), 16'($urandom_range(200)),
                 16'($urandom_range(2000)), 20'($urandom_range(200000, 2000)),
                 8'($urandom_range(30)));
    send_idle_pct = 0;
    recv_stall_pct = 0;
    want_hold = 1'b1;
    run_random(350);

    program_regs(8'($urandom_range(255, 1)), 16'($urandom_range(200)),
                 16'($urandom_range(2000)), 20'($urandom_range(200000, 2000)),
                 8'($urandom_range(30)));
    send_idle_pct = 33;
    recv_stall_pct = 33;
    run_random(350);

    wait_drained();
    repeat (40) @(negedge clk);
    if (sb.fail_count == 0 && sb.pending_reports.size() == 0) begin
      $display("rf_pulse_train_capture regression: pass");
    end else begin
      $display("rf_pulse_train_capture regression: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
